// ===== rtl/core/lbba_pkg.sv =====
package lbba_pkg;

	localparam int SAMPLES_PER_READING = 8;

	localparam int ADC_W      = 12;
	localparam int MV_W       = 14;
	localparam int SUM_W      = 16;
	localparam int SCNT_W     = 4;
	localparam int TONE_W     = 8;
	localparam int PAT_W      = 16;
	localparam int LOWT_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int SCALE_MUL   = 2475;
	localparam int SCALE_W     = 12;
	localparam int SCALE_SHIFT = 10;
	localparam int MV_MAX      = ((2 ** ADC_W - 1) * SCALE_MUL) / (2 ** SCALE_SHIFT);

	localparam logic [MV_W-1:0]   RST_LOW_THRESHOLD = MV_W'(6400);
	localparam logic [15:0]       RST_ALARM_DELAY   = 16'd5000;
	localparam logic [PAT_W-1:0]  RST_BEEP_ON       = PAT_W'(5000);
	localparam logic [PAT_W-1:0]  RST_BEEP_PERIOD   = PAT_W'(10000);
	localparam logic [TONE_W-1:0] RST_TONE_HALF     = TONE_W'(2);
	localparam logic [7:0]        RST_TICKS_PER_MS  = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_THRESHOLD = 3'd0,
		REG_ALARM_DELAY   = 3'd1,
		REG_BEEP_ON       = 3'd2,
		REG_BEEP_PERIOD   = 3'd3,
		REG_TONE_HALF     = 3'd4,
		REG_TICKS_PER_MS  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		CMD_TICK   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [MV_W-1:0]   low_threshold_mv;
		logic [LOWT_W-1:0] alarm_delay_ms;
		logic [PAT_W-1:0]  beep_on_ticks;
		logic [PAT_W-1:0]  beep_period_ticks;
		logic [TONE_W-1:0] tone_half_ticks;
		logic [7:0]        ticks_per_ms;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic sample;
	} step_t;

endpackage

// ===== rtl/core/lbba_cfg_regs.sv =====
module lbba_cfg_regs
	import lbba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold_mv  <= RST_LOW_THRESHOLD;
			cfg_q.alarm_delay_ms    <= RST_ALARM_DELAY;
			cfg_q.beep_on_ticks     <= RST_BEEP_ON;
			cfg_q.beep_period_ticks <= RST_BEEP_PERIOD;
			cfg_q.tone_half_ticks   <= RST_TONE_HALF;
			cfg_q.ticks_per_ms      <= RST_TICKS_PER_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_THRESHOLD: cfg_q.low_threshold_mv  <= cfg_wdata[MV_W-1:0];
				REG_ALARM_DELAY:   cfg_q.alarm_delay_ms    <= cfg_wdata[LOWT_W-1:0];
				REG_BEEP_ON:       cfg_q.beep_on_ticks     <= cfg_wdata[PAT_W-1:0];
				REG_BEEP_PERIOD:   cfg_q.beep_period_ticks <= cfg_wdata[PAT_W-1:0];
				REG_TONE_HALF:     cfg_q.tone_half_ticks   <= cfg_wdata[TONE_W-1:0];
				REG_TICKS_PER_MS:  cfg_q.ticks_per_ms      <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/lbba_adc_avg.sv =====
module lbba_adc_avg
	import lbba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  step_t            step,
	input  logic [ADC_W-1:0] adc_sample,
	output logic [MV_W-1:0]  voltage_mv,
	output logic [MV_W-1:0]  voltage_mv_nxt
);

	logic [SUM_W-1:0]          sum_q;
	logic [SCNT_W-1:0]         cnt_q;
	logic [MV_W-1:0]           mv_q;
	logic [SUM_W-1:0]          sum_new;
	logic [SCNT_W:0]           cnt_new;
	logic [SUM_W-1:0]          avg_full;
	logic [ADC_W-1:0]          avg;
	logic [ADC_W+SCALE_W-1:0]  prod;
	logic                      done;

	always_comb begin
		sum_new  = sum_q + SUM_W'(adc_sample);
		cnt_new  = {1'b0, cnt_q} + 1'b1;
		done     = cnt_new >= (SCNT_W+1)'(SAMPLES_PER_READING);
		avg_full = sum_new / SUM_W'(SAMPLES_PER_READING);
		avg      = avg_full[ADC_W-1:0];
		prod     = (ADC_W+SCALE_W)'(avg) * (ADC_W+SCALE_W)'(SCALE_MUL);
		voltage_mv_nxt = (step.sample && done) ? prod[SCALE_SHIFT +: MV_W] : mv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			mv_q  <= '0;
		end else if (step.sample) begin
			mv_q <= voltage_mv_nxt;
			if (done) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_new;
				cnt_q <= cnt_new[SCNT_W-1:0];
			end
		end
	end

	assign voltage_mv = mv_q;

endmodule

// ===== rtl/core/lbba_tick.sv =====
module lbba_tick
	import lbba_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  step_t           step,
	input  cfg_t            cfg,
	input  logic [MV_W-1:0] voltage_mv,
	output logic            buzzer_nxt,
	output logic            alarm_nxt
);

	logic [TONE_W-1:0] tone_cnt_q, tone_cnt_d, tone_inc;
	logic              tone_en_q, tone_en_d;
	logic              buzzer_q;
	logic [PAT_W-1:0]  pat_cnt_q, pat_cnt_d, pat_inc;
	logic [7:0]        sub_ms_q, sub_ms_d, sub_inc;
	logic [LOWT_W-1:0] low_time_q, low_time_d, low_inc;
	logic              alarm_q;

	always_comb begin
		tone_cnt_d = tone_cnt_q;
		buzzer_nxt = buzzer_q;
		tone_inc   = tone_cnt_q + 1'b1;
		if (step.tick) begin
			if (tone_en_q) begin
				if (tone_inc >= cfg.tone_half_ticks) begin
					tone_cnt_d = '0;
					buzzer_nxt = ~buzzer_q;
				end else begin
					tone_cnt_d = tone_inc;
				end
			end else begin
				buzzer_nxt = 1'b0;
			end
		end

		tone_en_d = tone_en_q;
		pat_cnt_d = pat_cnt_q;
		pat_inc   = pat_cnt_q + 1'b1;
		if (step.tick) begin
			if (!alarm_q) begin
				tone_en_d = 1'b0;
				pat_cnt_d = '0;
			end else if (pat_inc < cfg.beep_on_ticks) begin
				tone_en_d = 1'b1;
				pat_cnt_d = pat_inc;
			end else if (pat_inc < cfg.beep_period_ticks) begin
				tone_en_d = 1'b0;
				pat_cnt_d = pat_inc;
			end else begin
				pat_cnt_d = '0;
			end
		end

		sub_ms_d   = sub_ms_q;
		low_time_d = low_time_q;
		alarm_nxt  = alarm_q;
		sub_inc    = sub_ms_q + 1'b1;
		low_inc    = (&low_time_q) ? low_time_q : low_time_q + 1'b1;
		if (step.tick) begin
			if (sub_inc >= cfg.ticks_per_ms) begin
				sub_ms_d = '0;
				if (voltage_mv < cfg.low_threshold_mv) begin
					low_time_d = low_inc;
					if (low_inc > cfg.alarm_delay_ms)
						alarm_nxt = 1'b1;
				end else begin
					low_time_d = '0;
					alarm_nxt  = 1'b0;
				end
			end else begin
				sub_ms_d = sub_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_cnt_q <= '0;
			tone_en_q  <= 1'b0;
			buzzer_q   <= 1'b0;
			pat_cnt_q  <= '0;
			sub_ms_q   <= '0;
			low_time_q <= '0;
			alarm_q    <= 1'b0;
		end else begin
			tone_cnt_q <= tone_cnt_d;
			tone_en_q  <= tone_en_d;
			buzzer_q   <= buzzer_nxt;
			pat_cnt_q  <= pat_cnt_d;
			sub_ms_q   <= sub_ms_d;
			low_time_q <= low_time_d;
			alarm_q    <= alarm_nxt;
		end
	end

endmodule

// ===== rtl/core/low_battery_beep_alarm_unit.sv =====
// Low-battery beep alarm. Each input beat is either a 100 us tick (cmd 0) or a
// raw 12-bit battery ADC sample (cmd 1); every beat yields exactly one result
// beat carrying the buzzer pin level, the latched alarm flag and the latest
// averaged battery voltage in millivolts (0 until the first full group of
// eight samples). The block takes one beat per clock while its result is not
// stalled: a beat lands in an input register, and when it advances the tick and
// averaging state update in the same cycle as the result is captured in an output
// register; a stalled result holds only the input register behind it. Configuration
// writes take effect on the next beat and are meant for idle periods.
module low_battery_beep_alarm_unit
	import lbba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [ADC_W-1:0]      adc_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  buzzer_level,
	output logic                  alarm_active,
	output logic [MV_W-1:0]       battery_mv
);

	cfg_t             cfg;
	step_t            step;
	logic             valid_s1;
	logic             cmd_s1;
	logic [ADC_W-1:0] adc_s1;
	logic             s1_adv;
	logic             in_acc;
	logic             out_valid_q;
	logic             buzzer_level_q;
	logic             alarm_active_q;
	logic [MV_W-1:0]  battery_mv_q;
	logic             buzzer_nxt;
	logic             alarm_nxt;
	logic [MV_W-1:0]  voltage_mv;
	logic [MV_W-1:0]  voltage_mv_nxt;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign step     = {s1_adv && (cmd_s1 == CMD_TICK), s1_adv && (cmd_s1 == CMD_SAMPLE)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (s1_adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= cmd;
			adc_s1 <= adc_sample;
		end
		if (s1_adv) begin
			buzzer_level_q <= buzzer_nxt;
			alarm_active_q <= alarm_nxt;
			battery_mv_q   <= voltage_mv_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign buzzer_level = buzzer_level_q;
	assign alarm_active = alarm_active_q;
	assign battery_mv   = battery_mv_q;

	lbba_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lbba_adc_avg u_adc (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.adc_sample     (adc_s1),
		.voltage_mv     (voltage_mv),
		.voltage_mv_nxt (voltage_mv_nxt)
	);

	lbba_tick u_tick (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cfg        (cfg),
		.voltage_mv (voltage_mv),
		.buzzer_nxt (buzzer_nxt),
		.alarm_nxt  (alarm_nxt)
	);

	a_stall_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid)
		else $error("advanced beat produced no result");

	a_mv_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(battery_mv) <= MV_MAX))
		else $error("battery voltage out of range");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(step.tick && step.sample))
		else $error("tick and sample stepped together");

endmodule

// ===== bench/low_battery_beep_alarm_unit_tb.sv =====
`timescale 1ns / 100ps

module low_battery_beep_alarm_unit_tb;
	import lbba_pkg::*;

	localparam int MV_NUM = 2475;
	localparam int MV_DEN = 1024;
	localparam int QUIET_LIMIT = 5000;

	typedef struct packed {
		cmd_t            kind;
		logic [ADC_W-1:0] adc;
	} battery_beat_t;

	typedef struct packed {
		logic            buzzer;
		logic            alarm;
		logic [MV_W-1:0] mv;
	} alarm_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  cmd = 1'b0;
	logic [ADC_W-1:0]      adc_sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  buzzer_level;
	logic                  alarm_active;
	logic [MV_W-1:0]       battery_mv;

	low_battery_beep_alarm_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.adc_sample   (adc_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.buzzer_level (buzzer_level),
		.alarm_active (alarm_active),
		.battery_mv   (battery_mv)
	);

	battery_beat_t pending_beats[$];
	alarm_status_t pending_status[$];
	battery_beat_t next_beat;
	battery_beat_t seen_beat;
	alarm_status_t want;
	logic          in_taken = 1'b0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            quiet_cycles = 0;
	int            fails = 0;

	cfg_t              settings;
	logic [TONE_W-1:0] tone_cnt = '0;
	logic              tone_on = 1'b0;
	logic              buzz = 1'b0;
	logic [PAT_W-1:0]  pat_cnt = '0;
	logic [7:0]        ms_prescale = '0;
	logic [LOWT_W-1:0] low_ms = '0;
	logic              alarm_on = 1'b0;
	logic [MV_W-1:0]   volt_mv = '0;
	logic [SUM_W-1:0]  adc_sum = '0;
	logic [SCNT_W-1:0] n_samples = '0;

	function automatic alarm_status_t step_battery(battery_beat_t b);
		int unsigned reading;
		if (b.kind == CMD_SAMPLE) begin
			adc_sum = adc_sum + SUM_W'(b.adc);
			if (int'(n_samples) + 1 >= SAMPLES_PER_READING) begin
				reading = (int'(adc_sum) / SAMPLES_PER_READING) * MV_NUM / MV_DEN;
				volt_mv = MV_W'(reading);
				adc_sum = '0;
				n_samples = '0;
			end else begin
				n_samples = n_samples + 1'b1;
			end
		end else begin
			if (tone_on) begin
				tone_cnt = tone_cnt + 1'b1;
				if (tone_cnt >= settings.tone_half_ticks) begin
					tone_cnt = '0;
					buzz = ~buzz;
				end
			end else begin
				buzz = 1'b0;
			end
			if (!alarm_on) begin
				tone_on = 1'b0;
				pat_cnt = '0;
			end else begin
				pat_cnt = pat_cnt + 1'b1;
				if (pat_cnt < settings.beep_on_ticks)
					tone_on = 1'b1;
				else if (pat_cnt < settings.beep_period_ticks)
					tone_on = 1'b0;
				else
					pat_cnt = '0;
			end
			ms_prescale = ms_prescale + 1'b1;
			if (ms_prescale >= settings.ticks_per_ms) begin
				ms_prescale = '0;
				if (volt_mv < settings.low_threshold_mv) begin
					if (low_ms != '1)
						low_ms = low_ms + 1'b1;
					if (low_ms > settings.alarm_delay_ms)
						alarm_on = 1'b1;
				end else begin
					low_ms = '0;
					alarm_on = 1'b0;
				end
			end
		end
		return {buzz, alarm_on, volt_mv};
	endfunction

	function automatic cfg_t make_settings(int unsigned thr, int unsigned dly,
			int unsigned on_ticks, int unsigned per, int unsigned half, int unsigned tpm);
		cfg_t c;
		c.low_threshold_mv  = MV_W'(thr);
		c.alarm_delay_ms    = LOWT_W'(dly);
		c.beep_on_ticks     = PAT_W'(on_ticks);
		c.beep_period_ticks = PAT_W'(per);
		c.tone_half_ticks   = TONE_W'(half);
		c.ticks_per_ms      = 8'(tpm);
		return c;
	endfunction

	function automatic int unsigned pick_value(int unsigned top, int unsigned lo,
			int unsigned hi);
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 0;
		else if (r == 1)
			return top;
		return $urandom_range(lo, hi);
	endfunction

	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		case (r)
			REG_LOW_THRESHOLD: settings.low_threshold_mv = MV_W'(v);
			REG_ALARM_DELAY:   settings.alarm_delay_ms = LOWT_W'(v);
			REG_BEEP_ON:       settings.beep_on_ticks = PAT_W'(v);
			REG_BEEP_PERIOD:   settings.beep_period_ticks = PAT_W'(v);
			REG_TONE_HALF:     settings.tone_half_ticks = TONE_W'(v);
			REG_TICKS_PER_MS:  settings.ticks_per_ms = 8'(v);
			default: ;
		endcase
	endtask

	task automatic program_regs(cfg_t c);
		write_reg(REG_LOW_THRESHOLD, CFG_DATA_W'(c.low_threshold_mv));
		write_reg(REG_ALARM_DELAY, CFG_DATA_W'(c.alarm_delay_ms));
		write_reg(REG_BEEP_ON, CFG_DATA_W'(c.beep_on_ticks));
		write_reg(REG_BEEP_PERIOD, CFG_DATA_W'(c.beep_period_ticks));
		write_reg(REG_TONE_HALF, CFG_DATA_W'(c.tone_half_ticks));
		write_reg(REG_TICKS_PER_MS, CFG_DATA_W'(c.ticks_per_ms));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_beat(cmd_t k, logic [ADC_W-1:0] a);
		battery_beat_t b;
		b.kind = k;
		b.adc = a;
		pending_beats.push_back(b);
	endtask

	task automatic push_ticks(int n);
		repeat (n) push_beat(CMD_TICK, ADC_W'($urandom));
	endtask

	task automatic queue_random_traffic(int n);
		int queued;
		int r;
		int lo;
		int hi;
		int k;
		queued = 0;
		while (queued < n) begin
			r = $urandom_range(0, 9);
			if (r <= 6) begin
				if ($urandom_range(0, 3) == 0) begin
					lo = 0;
					hi = 4095;
				end else if ($urandom_range(0, 1)) begin
					lo = 0;
					hi = 1500;
				end else begin
					lo = 2600;
					hi = 4095;
				end
				repeat (SAMPLES_PER_READING)
					push_beat(CMD_SAMPLE, ADC_W'($urandom_range(lo, hi)));
				k = $urandom_range(1, 40);
				push_ticks(k);
				queued += SAMPLES_PER_READING + k;
			end else if (r <= 8) begin
				k = $urandom_range(1, SAMPLES_PER_READING - 1);
				repeat (k) push_beat(CMD_SAMPLE, ADC_W'($urandom));
				queued += k;
				k = $urandom_range(1, 20);
				push_ticks(k);
				queued += k;
			end else begin
				k = $urandom_range(1, 10);
				repeat (k) push_beat(cmd_t'($urandom_range(0, 1)), ADC_W'($urandom));
				queued += k;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_beats.size() > 0 || in_valid || pending_status.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial forever #4 clk = ~clk;

	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			if (!in_valid || in_taken) begin
				if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_beat = pending_beats.pop_front();
					in_valid <= 1'b1;
					cmd <= next_beat.kind;
					adc_sample <= next_beat.adc;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_status.size() == 0) begin
					$error("result beat with nothing pending");
					fails++;
				end else begin
					want = pending_status.pop_front();
					if (buzzer_level !== want.buzzer) begin
						$error("buzzer_level: expected %0d, got %0d", want.buzzer, buzzer_level);
						fails++;
					end
					if (alarm_active !== want.alarm) begin
						$error("alarm_active: expected %0d, got %0d", want.alarm, alarm_active);
						fails++;
					end
					if (battery_mv !== want.mv) begin
						$error("battery_mv: expected %0d, got %0d", want.mv, battery_mv);
						fails++;
					end
				end
			end
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				seen_beat.kind = cmd_t'(cmd);
				seen_beat.adc = adc_sample;
				pending_status.push_back(step_battery(seen_beat));
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		settings = make_settings(RST_LOW_THRESHOLD, RST_ALARM_DELAY, RST_BEEP_ON,
			RST_BEEP_PERIOD, RST_TONE_HALF, RST_TICKS_PER_MS);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				send_idle_pct = 27;
				recv_idle_pct = 74;
			end else if (p < 8) begin
				send_idle_pct = 74;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 0) begin
				program_regs(make_settings(16383, 0, 3, 5, 0, 0));
				repeat (SAMPLES_PER_READING) push_beat(CMD_SAMPLE, '1);
				push_ticks(6);
				push_beat(CMD_SAMPLE, '0);
				push_beat(CMD_SAMPLE, '1);
				repeat (3) begin
					push_beat(CMD_SAMPLE, 12'hAAA);
					push_beat(CMD_SAMPLE, 12'h555);
				end
				push_ticks(4);
			end else if (p == 4) begin
				program_regs(make_settings(16383, 65535, 65535, 65535, 255, 255));
				queue_random_traffic(130);
			end else begin
				program_regs(make_settings(pick_value(16383, 2000, 8000),
					pick_value(65535, 0, 30), pick_value(65535, 0, 12),
					pick_value(65535, 0, 20), pick_value(255, 1, 5),
					pick_value(255, 1, 4)));
				queue_random_traffic(130);
			end
			wait_idle();
		end

		// clear the alarm, then hold the voltage low
		program_regs(make_settings(0, 65535, 2, 4, 0, 0));
		repeat (SAMPLES_PER_READING) push_beat(CMD_SAMPLE, '0);
		push_ticks(3);
		wait_idle();
		program_regs(make_settings(16383, 65535, 2, 4, 0, 0));
		push_ticks(48);
		wait_idle();
		program_regs(make_settings(16383, 65534, 2, 4, 0, 0));
		push_ticks(20);
		wait_idle();

		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
